// ----- src/war_pkg.sv -----
// ----------------------------------------------------------------------------
// war_pkg - wildcard action rule table definitions
// Shared widths, command and status codes, and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package war_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_W       = 32;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_DEL   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BOTH_ZERO = 2'd2;

    typedef logic [KEY_W-1:0]       t_key;
    typedef logic [TABLE_DEPTH-1:0] t_slot_vec;

    typedef struct packed {
        logic [1:0] cmd;
        t_key       src_user;
        t_key       dst_user;
        t_key       action_code;
    } t_in_word;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } t_out_word;

endpackage

`default_nettype wire

// ----- src/war_if.sv -----
// ----------------------------------------------------------------------------
// war_if - valid/ready channels of the rule table
// Command channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface war_in_if import war_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface war_out_if import war_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/wildcard_action_rule_table.sv -----
// ----------------------------------------------------------------------------
// wildcard_action_rule_table - bounded rule table with wildcard delete/query
// Add stores a rule in the lowest free slot; delete clears all matching
// rules unless both users are zero; query reports whether any rule matches.
// ----------------------------------------------------------------------------
// channel   dir  modport  payload
// i_cmd     in   sink     cmd, src_user, dst_user, action_code
// o_res     out  source   hit, status
//
// One word enters per cycle while the input side is not stalled. A command is
// captured in the input register, then compared against all slots at once;
// table update and result register load happen at the same edge, so each
// command sees the last one's effect. Reset clears all valid bits at once;
// rule contents are not reset. A stalled result holds the input register,
// and the input side stalls only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_action_rule_table
    import war_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    war_in_if.sink    i_cmd,
    war_out_if.source o_res
);

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    t_slot_vec r_valid;
    t_key      r_rule_src [TABLE_DEPTH];
    t_key      r_rule_dst [TABLE_DEPTH];
    t_key      r_rule_act [TABLE_DEPTH];

    logic      out_free;
    logic      advance;
    t_slot_vec match;
    t_slot_vec free_vec;
    t_slot_vec first_free;
    t_slot_vec n_valid;
    t_out_word n_out;
    logic      both_zero;

    assign out_free = !r_out_valid || o_res.ready;
    assign advance  = r_in_valid && out_free;

    assign i_cmd.ready = !r_in_valid || advance;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    war_match u_match (
        .i_src      (r_in.src_user),
        .i_dst      (r_in.dst_user),
        .i_act      (r_in.action_code),
        .i_valid    (r_valid),
        .i_rule_src (r_rule_src),
        .i_rule_dst (r_rule_dst),
        .i_rule_act (r_rule_act),
        .o_match    (match)
    );

    // lowest free slot as a one-hot: x & -x
    assign free_vec   = ~r_valid;
    assign first_free = free_vec & (~free_vec + t_slot_vec'(1));
    assign both_zero  = (r_in.src_user == '0) && (r_in.dst_user == '0);

    always_comb begin
        n_valid = r_valid;
        n_out   = '{hit: 1'b0, status: ST_DONE};
        unique case (r_in.cmd)
            CMD_ADD: begin
                if (free_vec == '0) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_valid = r_valid | first_free;
                end
            end
            CMD_DEL: begin
                if (both_zero) begin
                    n_out.status = ST_BOTH_ZERO;
                end else begin
                    n_valid = r_valid & ~match;
                end
            end
            CMD_QUERY: begin
                n_out.hit = |match;
            end
            default: begin
                // unused code: no operation
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_valid     <= n_valid;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in <= i_cmd.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (advance && (r_in.cmd == CMD_ADD) && first_free[i]) begin
                r_rule_src[i] <= r_in.src_user;
                r_rule_dst[i] <= r_in.dst_user;
                r_rule_act[i] <= r_in.action_code;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/war_match.sv -----
// ----------------------------------------------------------------------------
// war_match - parallel wildcard compare
// Compares the keys against every stored rule; a zero key matches anything.
// ----------------------------------------------------------------------------
`default_nettype none

module war_match
    import war_pkg::*;
(
    input  wire t_key      i_src,
    input  wire t_key      i_dst,
    input  wire t_key      i_act,
    input  wire t_slot_vec i_valid,
    input  wire t_key      i_rule_src [TABLE_DEPTH],
    input  wire t_key      i_rule_dst [TABLE_DEPTH],
    input  wire t_key      i_rule_act [TABLE_DEPTH],
    output t_slot_vec      o_match
);

    logic src_any;
    logic dst_any;
    logic act_any;

    assign src_any = (i_src == '0);
    assign dst_any = (i_dst == '0);
    assign act_any = (i_act == '0);

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            o_match[i] = i_valid[i]
                       && (src_any || (i_rule_src[i] == i_src))
                       && (dst_any || (i_rule_dst[i] == i_dst))
                       && (act_any || (i_rule_act[i] == i_act));
        end
    end

endmodule

`default_nettype wire
